### rtl/nearest_centroid_search_assert.svh
// assertion macros for the nearest centroid search rtl
`ifndef NEAREST_CENTROID_SEARCH_ASSERT_SVH
`define NEAREST_CENTROID_SEARCH_ASSERT_SVH

// same-cycle implication
`define NCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ncs_pkg.sv
// shared types and constants of the nearest centroid search block
package ncs_pkg;

    localparam int CIDX_W = 10;
    localparam int EIDX_W = 7;
    localparam int VAL_W  = 16;
    localparam int IDX_W  = 10;
    localparam int DIST_W = 39;
    localparam int CFG_W  = 11;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic              wr_cent;
        logic              wr_qry;
        logic              search;
        logic              full_dims;
        logic [CIDX_W-1:0] cidx;
        logic [EIDX_W-1:0] eidx;
        logic [VAL_W-1:0]  value;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_op_req;

endpackage

### rtl/nearest_centroid_search.sv
// top level of the brute force nearest centroid search
//
// input channel (i_in_valid / o_in_stall): one transaction per element. cmd load writes
// element_index of centroid centroid_index into the store; cmd query writes one query
// element. a query transaction with last set closes the query and starts the search.
// load and plain query transactions are taken one per cycle through a four entry queue.
// the search walks centroids_in_use centroids over element 0 up to the last index, one
// element per cycle on the single centroid store read port; the result is loaded into
// the output register once the distance pipeline has drained. transactions behind a
// search wait in the queue, and the input stalls once it is full.
// output channel (o_out_valid / i_out_stall): one result per search, held in an output
// register while the receiver stalls; the next search waits at its end until it is free.
// config: i_cfg_wr_en writes centroids_in_use; the user writes it only while the block
// is idle, not enforced by the block. reset clears control state and sets centroids_in_use
// to 1024; store contents stay undefined until loaded, and there is no clearing pass.
module nearest_centroid_search #(
    parameter int NUM_CENTROIDS  = 1024,
    parameter int MAX_DIMENSIONS = 128,
    parameter int ELEMENT_BITS   = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [ncs_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_cmd,
    input  logic [ncs_pkg::CIDX_W-1:0] i_centroid_index,
    input  logic [ncs_pkg::EIDX_W-1:0] i_element_index,
    input  logic [ncs_pkg::VAL_W-1:0]  i_element_value,
    input  logic                       i_last,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ncs_pkg::IDX_W-1:0]  o_nearest_index,
    output logic [ncs_pkg::DIST_W-1:0] o_nearest_distance
);
    import ncs_pkg::*;

    t_op_req push;
    t_op_req head;
    logic    full;
    logic    pop;

    ncs_front #(
        .NUM_CENTROIDS  (NUM_CENTROIDS),
        .MAX_DIMENSIONS (MAX_DIMENSIONS)
    ) u_front (
        .i_valid          (i_in_valid),
        .o_stall          (o_in_stall),
        .i_cmd            (i_cmd),
        .i_centroid_index (i_centroid_index),
        .i_element_index  (i_element_index),
        .i_element_value  (i_element_value),
        .i_last           (i_last),
        .i_full           (full),
        .o_push           (push)
    );

    ncs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    ncs_back #(
        .NUM_CENTROIDS  (NUM_CENTROIDS),
        .MAX_DIMENSIONS (MAX_DIMENSIONS),
        .ELEMENT_BITS   (ELEMENT_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_head             (head),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_nearest_index    (o_nearest_index),
        .o_nearest_distance (o_nearest_distance)
    );

endmodule

### rtl/ncs_ram.sv
// generic single write port ram with registered read
module ncs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ncs_front.sv
// input acceptance and classification of load and query transactions
module ncs_front #(
    parameter int NUM_CENTROIDS  = 1024,
    parameter int MAX_DIMENSIONS = 128
) (
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [ncs_pkg::CIDX_W-1:0]    i_centroid_index,
    input  logic [ncs_pkg::EIDX_W-1:0]    i_element_index,
    input  logic [ncs_pkg::VAL_W-1:0]     i_element_value,
    input  logic                          i_last,
    input  logic                          i_full,
    output ncs_pkg::t_op_req              o_push
);
    import ncs_pkg::*;

    logic [31:0] cidx32;
    logic [31:0] eidx32;
    logic        cidx_ok;
    logic        eidx_ok;
    t_op         op;

    assign cidx32  = 32'(i_centroid_index);
    assign eidx32  = 32'(i_element_index);
    assign cidx_ok = cidx32 < 32'(NUM_CENTROIDS);
    assign eidx_ok = eidx32 < 32'(MAX_DIMENSIONS);

    always_comb begin
        op.wr_cent   = (i_cmd == CMD_LOAD) && cidx_ok && eidx_ok;
        op.wr_qry    = (i_cmd == CMD_QUERY) && eidx_ok;
        op.search    = (i_cmd == CMD_QUERY) && i_last;
        op.full_dims = !eidx_ok;
        op.cidx      = i_centroid_index;
        op.eidx      = i_element_index;
        op.value     = i_element_value;
    end

    // out of range loads have no effect and are dropped here
    assign o_stall      = i_full;
    assign o_push.valid = i_valid && !i_full && (op.wr_cent || op.wr_qry || op.search);
    assign o_push.op    = op;

endmodule

### rtl/ncs_queue.sv
// short operation queue between front and back
module ncs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ncs_pkg::t_op_req i_push,
    output logic             o_full,
    output ncs_pkg::t_op_req o_head,
    input  logic             i_pop
);
    import ncs_pkg::*;

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !i_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.op;
        end
    end

    assign o_full       = r_count == Q_CNT_W'(Q_DEPTH);
    assign o_head.valid = r_count != '0;
    assign o_head.op    = r_mem[r_rd_ptr];

endmodule

### rtl/ncs_back.sv
// stores, distance pipeline, search sequencer and result register
`include "nearest_centroid_search_assert.svh"

module ncs_back #(
    parameter int NUM_CENTROIDS  = 1024,
    parameter int MAX_DIMENSIONS = 128,
    parameter int ELEMENT_BITS   = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [ncs_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  ncs_pkg::t_op_req           i_head,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ncs_pkg::IDX_W-1:0]  o_nearest_index,
    output logic [ncs_pkg::DIST_W-1:0] o_nearest_distance
);
    import ncs_pkg::*;

    localparam int EW    = (ELEMENT_BITS < VAL_W) ? ELEMENT_BITS : VAL_W;
    localparam int CW    = (NUM_CENTROIDS > 1) ? $clog2(NUM_CENTROIDS) : 1;
    localparam int DIM_W = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
    localparam int SQ_W  = 2 * EW;
    localparam int SUM_W = SQ_W + DIM_W;
    localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(MAX_DIMENSIONS - 1);

    t_state             r_state;
    t_state             n_state;
    logic [CW-1:0]      r_cent;
    logic [CW-1:0]      n_cent;
    logic [DIM_W-1:0]   r_elem;
    logic [DIM_W-1:0]   n_elem;
    logic [CW-1:0]      r_last_cent;
    logic [CW-1:0]      n_last_cent;
    logic [DIM_W-1:0]   r_last_elem;
    logic [DIM_W-1:0]   n_last_elem;
    logic [CFG_W-1:0]   r_cfg;

    logic [31:0]        cfg32;
    logic [31:0]        cnt_last32;
    logic [CW-1:0]      cnt_last;
    logic [31:0]        op_cidx32;
    logic [31:0]        op_eidx32;
    logic [CW-1:0]      op_cidx;
    logic [DIM_W-1:0]   op_eidx;
    logic [EW-1:0]      op_value;

    logic               issue;
    logic               load_out;
    logic               pipe_busy;
    logic [EW-1:0]      q_rdata;
    logic [EW-1:0]      c_rdata;

    logic               r_p1_v;
    logic               r_p1_first;
    logic               r_p1_last;
    logic [CW-1:0]      r_p1_cid;
    logic               r_p2_v;
    logic               r_p2_first;
    logic               r_p2_last;
    logic [CW-1:0]      r_p2_cid;
    logic [EW-1:0]      r_d;
    logic               r_p3_v;
    logic               r_p3_first;
    logic               r_p3_last;
    logic [CW-1:0]      r_p3_cid;
    logic [SQ_W-1:0]    r_sq;
    logic               r_p4_v;
    logic [CW-1:0]      r_p4_cid;
    logic [SUM_W-1:0]   r_acc;
    logic [SUM_W-1:0]   r_best;
    logic [CW-1:0]      r_best_id;

    logic [EW-1:0]      abs_diff;
    logic [SQ_W-1:0]    sq_w;
    logic [SUM_W-1:0]   sq_ext;
    logic [31:0]        id32;
    logic [63:0]        best64;

    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_idx;
    logic [DIST_W-1:0]  r_out_dist;

    // count register, clamped to one through the store size
    assign cfg32      = 32'(r_cfg);
    assign cnt_last32 = (cfg32 == 32'd0) ? 32'd0 :
                        (cfg32 > 32'(NUM_CENTROIDS)) ? 32'(NUM_CENTROIDS - 1) :
                        cfg32 - 32'd1;
    assign cnt_last   = cnt_last32[CW-1:0];

    assign op_cidx32 = 32'(i_head.op.cidx);
    assign op_eidx32 = 32'(i_head.op.eidx);
    assign op_cidx   = op_cidx32[CW-1:0];
    assign op_eidx   = op_eidx32[DIM_W-1:0];
    assign op_value  = i_head.op.value[EW-1:0];

    assign issue     = r_state == S_RUN;
    assign pipe_busy = r_p1_v || r_p2_v || r_p3_v || r_p4_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cent      = r_cent;
        n_elem      = r_elem;
        n_last_cent = r_last_cent;
        n_last_elem = r_last_elem;
        o_pop       = 1'b0;
        load_out    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (i_head.op.search) begin
                        n_state     = S_RUN;
                        n_cent      = '0;
                        n_elem      = '0;
                        n_last_cent = cnt_last;
                        n_last_elem = i_head.op.full_dims ? DIM_LAST : op_eidx;
                    end
                end
            end
            S_RUN: begin
                if (r_elem == r_last_elem) begin
                    n_elem = '0;
                    if (r_cent == r_last_cent) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_cent = r_cent + CW'(1);
                    end
                end else begin
                    n_elem = r_elem + DIM_W'(1);
                end
            end
            S_DRAIN: begin
                if (!pipe_busy && (!r_out_valid || !i_out_stall)) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cent      <= n_cent;
        r_elem      <= n_elem;
        r_last_cent <= n_last_cent;
        r_last_elem <= n_last_elem;
    end

    ncs_ram #(
        .WIDTH (EW),
        .DEPTH (2 ** DIM_W)
    ) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (o_pop && i_head.op.wr_qry),
        .i_waddr (op_eidx),
        .i_wdata (op_value),
        .i_raddr (r_elem),
        .o_rdata (q_rdata)
    );

    ncs_ram #(
        .WIDTH (EW),
        .DEPTH (2 ** (CW + DIM_W))
    ) u_centroid_ram (
        .i_clk   (i_clk),
        .i_we    (o_pop && i_head.op.wr_cent),
        .i_waddr ({op_cidx, op_eidx}),
        .i_wdata (op_value),
        .i_raddr ({r_cent, r_elem}),
        .o_rdata (c_rdata)
    );

    // distance pipeline: read, difference, square, accumulate, compare
    assign abs_diff = (q_rdata >= c_rdata) ? (q_rdata - c_rdata) : (c_rdata - q_rdata);
    assign sq_w     = {{EW{1'b0}}, r_d} * {{EW{1'b0}}, r_d};
    assign sq_ext   = {{DIM_W{1'b0}}, r_sq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
        end else begin
            r_p1_v <= issue;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v && r_p3_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_first <= r_elem == '0;
        r_p1_last  <= r_elem == r_last_elem;
        r_p1_cid   <= r_cent;
        r_d        <= abs_diff;
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_cid   <= r_p1_cid;
        r_sq       <= sq_w;
        r_p3_first <= r_p2_first;
        r_p3_last  <= r_p2_last;
        r_p3_cid   <= r_p2_cid;
        if (r_p3_v) begin
            r_acc <= r_p3_first ? sq_ext : r_acc + sq_ext;
        end
        r_p4_cid <= r_p3_cid;
        // strict less-than keeps the lowest index on ties
        if (r_p4_v && (r_p4_cid == '0 || r_acc < r_best)) begin
            r_best    <= r_acc;
            r_best_id <= r_p4_cid;
        end
    end

    assign id32   = 32'(r_best_id);
    assign best64 = 64'(r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_idx  <= id32[IDX_W-1:0];
            r_out_dist <= best64[DIST_W-1:0];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_nearest_index    = r_out_idx;
    assign o_nearest_distance = r_out_dist;

    `NCS_ASSERT_IMP(a_result_after_drain, i_clk, i_rst_n, $rose(r_out_valid), !pipe_busy, "result loaded while pipeline busy")
    `NCS_ASSERT_IMP(a_walk_in_range, i_clk, i_rst_n, r_state == S_RUN, (r_cent <= r_last_cent) && (r_elem <= r_last_elem), "search counters past limit")
    `NCS_ASSERT_NXT(a_hold_on_stall, i_clk, i_rst_n, (r_state == S_DRAIN) && r_out_valid && i_out_stall, r_state == S_DRAIN, "search finished over a stalled result")

endmodule
